@@ rtl/rau_pkg.sv @@
// Shared types and constants for the rational arithmetic unit.
`default_nettype none

package rau_pkg;

  localparam int FIELD_W = 16;
  localparam int DATA_W  = 32;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_GCD,
    ST_REM,
    ST_QNUM,
    ST_QDEN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]                mode;
    logic signed [FIELD_W-1:0] a_num;
    logic signed [FIELD_W-1:0] a_den;
    logic signed [FIELD_W-1:0] b_num;
    logic signed [FIELD_W-1:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] res_num;
    logic signed [DATA_W-1:0] res_den;
    logic                     div_zero;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/rau_divider.sv @@
// Radix-2 restoring signed divider with truncating quotient and remainder.
`default_nettype none

module rau_divider (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [rau_pkg::DATA_W-1:0] dividend,
  input  wire logic [rau_pkg::DATA_W-1:0] divisor,
  output logic                           done,
  output logic [rau_pkg::DATA_W-1:0]     quotient,
  output logic [rau_pkg::DATA_W-1:0]     remainder
);
  import rau_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DATA_W - 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] quo_r;
  logic [DATA_W-1:0] dvs_r;
  logic              qneg_r;
  logic              rneg_r;

  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] dividend_mag;
  logic [DATA_W-1:0] divisor_mag;

  assign dividend_mag = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
  assign divisor_mag  = divisor[DATA_W-1]  ? (~divisor + 1'b1)  : divisor;
  assign trial        = {rem_r, quo_r[DATA_W-1]};
  assign diff         = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quo_r  <= dividend_mag;
      dvs_r  <= divisor_mag;
      qneg_r <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
      rneg_r <= dividend[DATA_W-1];
    end else if (busy_r) begin
      if (!diff[DATA_W]) begin
        rem_r <= diff[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign done      = done_r;
  assign quotient  = qneg_r ? (~quo_r + 1'b1) : quo_r;
  assign remainder = rneg_r ? (~rem_r + 1'b1) : rem_r;

endmodule

`default_nettype wire

@@ rtl/rational_arith_unit_core.sv @@
// Top level of the rational arithmetic unit: sequencer, shared multiplier, shared divider and output register.
`default_nettype none

// Adds, subtracts, multiplies or divides two signed fractions and returns the
// result reduced by Euclid's gcd with truncating remainders, so the signs of
// the reduced pair follow the C convention and are not normalized. One
// transaction is taken at a time: in_stall is high from the cycle after a
// transaction is accepted until its result has been placed in the output
// register, and the output register lets the next transaction enter while the
// previous result still waits for the consumer. A transaction takes three
// products on the shared 32x32 multiplier, one combine step, and then a series
// of divisions on one shared radix-2 divider: one per Euclid remainder step (up
// to about 46 for 32-bit values) plus two for the final reduction of numerator
// and denominator. Each Euclid step also passes through a test of the
// remainder, and one more test comes before the two reductions. The time
// from one acceptance to the next, when the consumer does not stall, grows
// with the number of Euclid steps and is set by the divider loop, far less for
// small operands than in the worst case. Divide by a zero fraction yields 0/1
// with div_zero set; a result of 0/0 is returned unreduced, and a zero
// denominator is not checked. Operands are taken as OPERAND_WIDTH-bit two's
// complement values from the low bits of each field, and all intermediate
// values wrap to 32 bits.
module rational_arith_unit_core #(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire rau_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rau_pkg::out_item_t      out_data
);
  import rau_pkg::*;

  // Shift that places an operand's sign bit at the top of a 32-bit word.
  localparam int SH = DATA_W - OPERAND_WIDTH;

  function automatic logic [DATA_W-1:0] sext_op(input logic [FIELD_W-1:0] f);
    logic signed [DATA_W-1:0] t;
    t = signed'({{(DATA_W-FIELD_W){1'b0}}, f} << SH);
    return t >>> SH;
  endfunction

  state_t            state_r;
  state_t            state_nxt;
  mode_t             mode_r;
  logic [DATA_W-1:0] an_r, ad_r, bn_r, bd_r;
  logic [DATA_W-1:0] p0_r, p1_r, p2_r;
  logic [DATA_W-1:0] rn_r, rd_r;
  logic [DATA_W-1:0] x_r, y_r;
  logic              dz_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic [DATA_W-1:0] mult_a, mult_b, mul_lo;
  logic [DATA_W-1:0] sum_num, sum_den;
  logic              sum_dz;
  logic              den_eq;
  logic              div_start;
  logic [DATA_W-1:0] div_dividend, div_divisor;
  logic              div_done;
  logic [DATA_W-1:0] div_quo, div_rem;
  logic              out_load;
  logic              in_accept;

  assign in_accept = in_valid && !in_stall;

  // The shared multiplier: only the low word of each product is ever needed,
  // since every intermediate value wraps to 32 bits.
  assign mul_lo = mult_a * mult_b;

  rau_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Combine the products, or the numerators when the denominators are equal, into the raw numerator and denominator.
  assign den_eq = (ad_r == bd_r);

  always_comb begin
    sum_num = p0_r;
    sum_den = p1_r;
    sum_dz  = 1'b0;
    unique case (mode_r)
      MODE_ADD: begin
        if (den_eq) begin
          sum_num = an_r + bn_r;
          sum_den = ad_r;
        end else begin
          sum_num = p0_r + p1_r;
          sum_den = p2_r;
        end
      end
      MODE_SUB: begin
        if (den_eq) begin
          sum_num = an_r - bn_r;
          sum_den = ad_r;
        end else begin
          sum_num = p0_r - p1_r;
          sum_den = p2_r;
        end
      end
      MODE_MUL: begin
        sum_num = p0_r;
        sum_den = p1_r;
      end
      MODE_DIV: begin
        if (bn_r == '0) begin
          sum_num = '0;
          sum_den = DATA_W'(1);
          sum_dz  = 1'b1;
        end else begin
          sum_num = p0_r;
          sum_den = p1_r;
        end
      end
      default: begin
        sum_num = p0_r;
        sum_den = p1_r;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_MUL0;
      ST_MUL0: state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_GCD;
      ST_GCD: begin
        priority if (y_r != '0) state_nxt = ST_REM;
        else if (x_r != '0)     state_nxt = ST_QNUM;
        else                    state_nxt = ST_DONE;
      end
      ST_REM:  if (div_done) state_nxt = ST_GCD;
      ST_QNUM: if (div_done) state_nxt = ST_QDEN;
      ST_QDEN: if (div_done) state_nxt = ST_DONE;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: multiplier operands and divider requests.
  always_comb begin
    mult_a       = an_r;
    mult_b       = bd_r;
    div_start    = 1'b0;
    div_dividend = x_r;
    div_divisor  = y_r;
    out_load     = 1'b0;
    in_stall     = (state_r != ST_IDLE);
    unique case (state_r)
      ST_MUL0: begin
        mult_a = an_r;
        mult_b = (mode_r == MODE_MUL) ? bn_r : bd_r;
      end
      ST_MUL1: begin
        priority if (mode_r == MODE_MUL) begin
          mult_a = ad_r;
          mult_b = bd_r;
        end else if (mode_r == MODE_DIV) begin
          mult_a = ad_r;
          mult_b = bn_r;
        end else begin
          mult_a = bn_r;
          mult_b = ad_r;
        end
      end
      ST_MUL2: begin
        mult_a = ad_r;
        mult_b = bd_r;
      end
      ST_GCD: begin
        if (y_r != '0) begin
          // One Euclid step: x % y.
          div_start    = 1'b1;
          div_dividend = x_r;
          div_divisor  = y_r;
        end else if (x_r != '0) begin
          // The gcd is x; reduce the numerator first.
          div_start    = 1'b1;
          div_dividend = rn_r;
          div_divisor  = x_r;
        end
      end
      ST_QNUM: begin
        div_start    = div_done;
        div_dividend = rd_r;
        div_divisor  = x_r;
      end
      ST_DONE: out_load = !out_valid_r || !out_stall;
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      mode_r <= mode_t'(in_data.mode);
      an_r   <= sext_op(in_data.a_num);
      ad_r   <= sext_op(in_data.a_den);
      bn_r   <= sext_op(in_data.b_num);
      bd_r   <= sext_op(in_data.b_den);
    end
    if (state_r == ST_MUL0) p0_r <= mul_lo;
    if (state_r == ST_MUL1) p1_r <= mul_lo;
    if (state_r == ST_MUL2) p2_r <= mul_lo;
    if (state_r == ST_SUM) begin
      rn_r <= sum_num;
      rd_r <= sum_den;
      x_r  <= sum_num;
      y_r  <= sum_den;
      dz_r <= sum_dz;
    end
    if (state_r == ST_REM && div_done) begin
      x_r <= y_r;
      y_r <= div_rem;
    end
    if (state_r == ST_QNUM && div_done) rn_r <= div_quo;
    if (state_r == ST_QDEN && div_done) rd_r <= div_quo;
    if (out_load) begin
      out_data_r.res_num  <= rn_r;
      out_data_r.res_den  <= rd_r;
      out_data_r.div_zero <= dz_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A divide by a zero fraction always reports the forced 0/1 result.
  a_dz_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.div_zero |-> out_data.res_num == '0 && out_data.res_den == 1)
    else $error("div_zero result is not 0/1");

  // Once a transaction is taken, no further one enters in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> in_stall)
    else $error("input accepted while a transaction is in progress");

  // Divider completions only arrive while the sequencer waits for one.
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_REM || state_r == ST_QNUM || state_r == ST_QDEN)
    else $error("divider finished outside a wait state");

  // The divider is never started with a zero divisor, whether for a Euclid step or with the gcd.
  a_no_zero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> div_divisor != '0)
    else $error("divider started with a zero divisor");

endmodule

`default_nettype wire
